[rtl/scsa_pkg.sv]
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types and constants for the size-class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

    localparam int MAX_HANDLES = 1024;
    localparam int MAX_COMP    = 16;
    localparam int NUM_CLASSES = 10;
    localparam int HW          = $clog2(MAX_HANDLES);
    localparam int CW          = 4;
    localparam int STK_DEPTH   = NUM_CLASSES * MAX_HANDLES;
    localparam int STK_AW      = $clog2(STK_DEPTH);
    localparam logic [15:0] NO_HANDLE = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_BIG  = 3'd1,
        ST_OOM      = 3'd2,
        ST_BAD      = 3'd3,
        ST_IGNORED  = 3'd4,
        ST_NO_HDL   = 3'd5
    } status_t;

    localparam logic [1:0] REG_MAX_COMP = 2'd0;
    localparam logic [1:0] REG_PAGES    = 2'd1;
    localparam logic [1:0] REG_PAGE_L2  = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic        too_big;
        logic [3:0]  cls;
        logic [31:0] size;
        logic [15:0] hnd;
    } req_t;

endpackage

[rtl/scsa_front.sv]
// ----------------------------------------------------------------------------
// scsa_front
// Accepts commands, rounds sizes to a class and queues the request.
// ----------------------------------------------------------------------------
module scsa_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           command,
    input  logic [31:0]          requested_size,
    input  logic [15:0]          handle,
    output logic                 busy,
    output scsa_pkg::req_t       q_data,
    output logic                 q_valid,
    input  logic                 q_pop
);
    import scsa_pkg::*;

    req_t q_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    req_t cls_req;

    always_comb
    begin
        cls_req.cmd     = cmd_t'(command);
        cls_req.size    = requested_size;
        cls_req.hnd     = handle;
        cls_req.too_big = 1'b1;
        cls_req.cls     = 4'd0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if ({1'b0, requested_size} <= (33'd8192 << c))
            begin
                cls_req.too_big = 1'b0;
                cls_req.cls     = 4'(c);
            end
        end
    end

    assign busy    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            q_reg[wp_reg] <= cls_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (start && !busy)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(start && !busy) - 2'(q_pop);
        end
    end

endmodule

[rtl/scsa_back.sv]
// ----------------------------------------------------------------------------
// scsa_back
// Executes queued requests against handle, stack and carve state.
// ----------------------------------------------------------------------------
module scsa_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scsa_pkg::req_t       q_data,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  logic [4:0]           max_comp_cfg,
    input  logic [6:0]           pages_cfg,
    input  logic [4:0]           page_l2_cfg,
    output logic                 done,
    output logic [2:0]           status,
    output logic [15:0]          result_handle,
    output logic [3:0]           compartment,
    output logic [29:0]          slot_offset,
    output logic [3:0]           size_class,
    output logic                 entry_valid,
    output logic                 new_compartment,
    output logic [3:0]           new_compartment_index,
    output logic [31:0]          allocated_bytes,
    output logic [31:0]          wasted_bytes
);
    import scsa_pkg::*;

    typedef enum logic [0:0] { S_READ, S_EXEC } state_t;
    state_t state_reg;

    logic [38:0] hent_mem [MAX_HANDLES];
    logic [33:0] stk_mem  [STK_DEPTH];
    logic [HW-1:0] rec_mem [MAX_HANDLES];
    logic [38:0] hent_rd;
    logic [33:0] stk_rd;
    logic [HW-1:0] rec_rd;

    logic [4:0]  comp_open_reg;
    logic [6:0]  pages_left_reg;
    logic [3:0]  cv_comp_reg [NUM_CLASSES];
    logic [29:0] cv_next_reg [NUM_CLASSES];
    logic [11:0] cv_left_reg [NUM_CLASSES];
    logic [HW:0] top_reg     [NUM_CLASSES];
    logic [HW:0] hcount_reg, rtop_reg;
    logic [31:0] bytes_reg, waste_reg;

    logic [3:0]  cls;
    logic [HW-1:0] top_m1;
    logic [HW-1:0] h_idx;
    logic [STK_AW-1:0] stk_rd_addr, stk_wr_addr;

    assign cls   = q_data.cls;
    assign top_m1 = HW'(top_reg[cls] - 1'b1);
    assign h_idx  = q_data.hnd[HW-1:0];
    assign stk_rd_addr = STK_AW'(cls) * STK_AW'(MAX_HANDLES) + STK_AW'(top_m1);
    assign q_pop = (state_reg == S_EXEC);

    always_ff @(posedge clk)
    begin
        hent_rd <= hent_mem[h_idx];
        stk_rd  <= stk_mem[stk_rd_addr];
        rec_rd  <= rec_mem[HW'(rtop_reg - 1'b1)];
    end

    // effective config
    logic [6:0] ppc;
    logic [4:0] pl2, mxc;
    always_comb
    begin
        ppc = (pages_cfg == 7'd0) ? 7'd1 : ((pages_cfg > 7'd64) ? 7'd64 : pages_cfg);
        pl2 = (page_l2_cfg < 5'd22) ? 5'd22 : ((page_l2_cfg > 5'd24) ? 5'd24 : page_l2_cfg);
        mxc = (max_comp_cfg > 5'd16) ? 5'd16 : max_comp_cfg;
    end

    // allocate decision
    logic        a_pop, a_newc, a_ok, a_newpage;
    logic [6:0]  a_pl, a_pidx;
    logic [3:0]  a_comp;
    logic [29:0] a_off;
    logic [31:0] slot_sz;
    logic        e_hvalid;
    logic [3:0]  e_cls;
    always_comb
    begin
        slot_sz  = 32'd8192 << cls;
        a_pop    = (top_reg[cls] != '0);
        a_newpage = !a_pop && (cv_left_reg[cls] == '0);
        a_newc   = a_newpage && (pages_left_reg == 7'd0);
        a_ok     = !(a_newc && (comp_open_reg >= mxc));
        a_pl     = a_newc ? ppc : pages_left_reg;
        a_pidx   = (a_pl > ppc) ? 7'd0 : 7'(ppc - a_pl);
        if (a_pop)
        begin
            a_comp = stk_rd[33:30];
            a_off  = stk_rd[29:0];
        end
        else if (a_newpage)
        begin
            a_comp = 4'(comp_open_reg + 5'(a_newc) - 5'd1);
            a_off  = 30'({23'd0, a_pidx} << pl2);
        end
        else
        begin
            a_comp = cv_comp_reg[cls];
            a_off  = cv_next_reg[cls];
        end
        e_hvalid = ({{(16-HW-1){1'b0}}, hcount_reg} > q_data.hnd);
        e_cls    = hent_rd[37:34];
    end

    assign stk_wr_addr = STK_AW'(e_cls) * STK_AW'(MAX_HANDLES) + STK_AW'(top_reg[e_cls]);

    logic do_alloc, do_free, no_hdl;
    logic [HW-1:0] new_h;
    always_comb
    begin
        no_hdl   = (rtop_reg == '0) && (hcount_reg >= (HW+1)'(MAX_HANDLES));
        do_alloc = (state_reg == S_EXEC) && (q_data.cmd == CMD_ALLOC) && !q_data.too_big
                   && !no_hdl && a_ok;
        do_free  = (state_reg == S_EXEC) && (q_data.cmd == CMD_FREE)
                   && (q_data.hnd != NO_HANDLE) && e_hvalid && hent_rd[38];
        new_h    = (rtop_reg != '0) ? rec_rd : HW'(hcount_reg);
    end

    always_ff @(posedge clk)
    begin
        if (do_alloc)
        begin
            hent_mem[new_h] <= {1'b1, cls, a_comp, a_off};
        end
        else if (do_free)
        begin
            hent_mem[h_idx] <= {1'b0, hent_rd[37:0]};
            rec_mem[HW'(rtop_reg)] <= h_idx;
            if (e_cls < 4'(NUM_CLASSES))
            begin
                stk_mem[stk_wr_addr] <= hent_rd[33:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_READ;
            comp_open_reg  <= '0;
            pages_left_reg <= '0;
            hcount_reg     <= '0;
            rtop_reg       <= '0;
            bytes_reg      <= '0;
            waste_reg      <= '0;
            done           <= 1'b0;
            status         <= ST_OK;
            result_handle  <= NO_HANDLE;
            compartment    <= '0;
            slot_offset    <= '0;
            size_class     <= '0;
            entry_valid    <= 1'b0;
            new_compartment <= 1'b0;
            new_compartment_index <= '0;
            allocated_bytes <= '0;
            wasted_bytes    <= '0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                cv_comp_reg[c] <= '0;
                cv_next_reg[c] <= '0;
                cv_left_reg[c] <= '0;
                top_reg[c]     <= '0;
            end
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_READ:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg       <= S_READ;
                    done            <= 1'b1;
                    result_handle   <= NO_HANDLE;
                    compartment     <= '0;
                    slot_offset     <= '0;
                    size_class      <= '0;
                    entry_valid     <= 1'b0;
                    new_compartment <= 1'b0;
                    new_compartment_index <= '0;
                    allocated_bytes <= bytes_reg;
                    wasted_bytes    <= waste_reg;
                    status          <= ST_OK;
                    case (q_data.cmd)
                        CMD_ALLOC:
                        begin
                            if (q_data.too_big)
                            begin
                                status <= ST_TOO_BIG;
                            end
                            else if (no_hdl)
                            begin
                                status <= ST_NO_HDL;
                            end
                            else if (!a_ok)
                            begin
                                status <= ST_OOM;
                            end
                            else
                            begin
                                if (a_newc)
                                begin
                                    new_compartment       <= 1'b1;
                                    new_compartment_index <= comp_open_reg[3:0];
                                    comp_open_reg         <= comp_open_reg + 5'd1;
                                end
                                if (a_pop)
                                begin
                                    top_reg[cls] <= top_reg[cls] - 1'b1;
                                end
                                else if (a_newpage)
                                begin
                                    pages_left_reg   <= a_pl - 7'd1;
                                    cv_comp_reg[cls] <= a_comp;
                                    cv_next_reg[cls] <= 30'(a_off + slot_sz[29:0]);
                                    cv_left_reg[cls] <= 12'((13'd1 << (pl2 - 5'd13 - 5'(cls)))
                                                       - 13'd1);
                                end
                                else
                                begin
                                    cv_next_reg[cls] <= 30'(a_off + slot_sz[29:0]);
                                    cv_left_reg[cls] <= cv_left_reg[cls] - 12'd1;
                                end
                                if (rtop_reg != '0)
                                begin
                                    rtop_reg <= rtop_reg - 1'b1;
                                end
                                else
                                begin
                                    hcount_reg <= hcount_reg + 1'b1;
                                end
                                bytes_reg       <= bytes_reg + q_data.size;
                                waste_reg       <= waste_reg + slot_sz - q_data.size;
                                allocated_bytes <= bytes_reg + q_data.size;
                                wasted_bytes    <= waste_reg + slot_sz - q_data.size;
                                result_handle   <= 16'(new_h);
                                compartment     <= a_comp;
                                slot_offset     <= a_off;
                                size_class      <= cls;
                                entry_valid     <= 1'b1;
                            end
                        end
                        CMD_FREE, CMD_LOOKUP:
                        begin
                            if (q_data.hnd == NO_HANDLE)
                            begin
                                status <= ST_IGNORED;
                            end
                            else if (!e_hvalid || (q_data.cmd == CMD_FREE && !hent_rd[38]))
                            begin
                                status <= ST_BAD;
                            end
                            else
                            begin
                                compartment <= hent_rd[33:30];
                                slot_offset <= hent_rd[29:0];
                                size_class  <= e_cls;
                                entry_valid <= (q_data.cmd == CMD_LOOKUP) && hent_rd[38];
                                if (q_data.cmd == CMD_FREE)
                                begin
                                    if (e_cls < 4'(NUM_CLASSES))
                                    begin
                                        top_reg[e_cls] <= top_reg[e_cls] + 1'b1;
                                    end
                                    rtop_reg <= rtop_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            status <= ST_IGNORED;
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_READ;
                end
            endcase
        end
    end

endmodule

[rtl/size_class_slab_allocator_top.sv]
// ----------------------------------------------------------------------------
// size_class_slab_allocator_top
// Slab allocator: command front end, two-entry queue, execution back end.
// ----------------------------------------------------------------------------
// Sequence: a command is written into the queue, the memories are read, then
// the request executes and done is raised. The back end takes a new request only
// after the last one has executed, because of the read-then-update of the handle and freed-slot memories.
// Reset: control and counters clear asynchronously; memories are not cleared.
// The receiver cannot stall: each result is shown for one cycle with done.
module size_class_slab_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] requested_size,
    input  logic [15:0] handle,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] result_handle,
    output logic [3:0]  compartment,
    output logic [29:0] slot_offset,
    output logic [3:0]  size_class,
    output logic        entry_valid,
    output logic        new_compartment,
    output logic [3:0]  new_compartment_index,
    output logic [31:0] allocated_bytes,
    output logic [31:0] wasted_bytes
);
    import scsa_pkg::*;

    logic [4:0] max_comp_reg;
    logic [6:0] pages_reg;
    logic [4:0] page_l2_reg;
    req_t q_data;
    logic q_valid, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_comp_reg <= 5'd4;
            pages_reg    <= 7'd64;
            page_l2_reg  <= 5'd22;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_COMP: max_comp_reg <= cfg_data[4:0];
                REG_PAGES:    pages_reg    <= cfg_data;
                REG_PAGE_L2:  page_l2_reg  <= cfg_data[4:0];
                default:      ;
            endcase
        end
    end

    scsa_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .requested_size(requested_size), .handle(handle), .busy(busy),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
    );

    scsa_back u_back (
        .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
        .max_comp_cfg(max_comp_reg), .pages_cfg(pages_reg), .page_l2_cfg(page_l2_reg),
        .done(done), .status(status), .result_handle(result_handle),
        .compartment(compartment), .slot_offset(slot_offset), .size_class(size_class),
        .entry_valid(entry_valid), .new_compartment(new_compartment),
        .new_compartment_index(new_compartment_index),
        .allocated_bytes(allocated_bytes), .wasted_bytes(wasted_bytes)
    );

endmodule
